@@ rtl/spq_pkg.sv @@
package spq_pkg;

	localparam int QUEUE_DEPTH = 128;
	localparam int ID_WIDTH    = 16;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = 8;
	localparam int SLOT_W      = 6;
	localparam int BLK_W       = 16;
	localparam int FIELD_ID_W  = 16;

	localparam logic [SLOT_W-1:0] BLOCK_SIZE_RST = SLOT_W'(6);
	localparam logic [BLK_W-1:0]  BLOCK_NUM_RST  = BLK_W'(1);

	typedef enum logic {
		CMD_ENQUEUE = 1'b0,
		CMD_SERVE   = 1'b1
	} command_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_WORK = 1'b1
	} state_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [1:0]            status;
		logic [FIELD_ID_W-1:0] served_id;
		logic                  served_priority;
		logic [SLOT_W-1:0]     slot_index;
		logic                  last_in_block;
		logic [BLK_W-1:0]      block_number;
		logic [CNT_W-1:0]      priority_count;
		logic [CNT_W-1:0]      general_count;
	} rsp_t;

endpackage

@@ rtl/spq_if.sv @@
interface spq_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [15:0] customer_id;
	logic        is_priority;

	modport source (output valid, command, customer_id, is_priority, input ready);
	modport sink   (input valid, command, customer_id, is_priority, output ready);
endinterface

interface spq_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] served_id;
	logic        served_priority;
	logic [5:0]  slot_index;
	logic        last_in_block;
	logic [15:0] block_number;
	logic [7:0]  priority_count;
	logic [7:0]  general_count;

	modport source (output valid, status, served_id, served_priority, slot_index,
		last_in_block, block_number, priority_count, general_count, input ready);
	modport sink   (input valid, status, served_id, served_priority, slot_index,
		last_in_block, block_number, priority_count, general_count, output ready);
endinterface

@@ rtl/spq_ctrl.sv @@
module spq_ctrl
	import spq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output ctrl_cmd_t  cmd
);

	state_t state_q, state_d;
	logic   rsp_valid_q, rsp_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		rsp_valid_d = rsp_valid_q && !rsp_ready;
		cmd         = '0;
		req_ready   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_WORK;
				end
			end
			S_WORK: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.commit  = 1'b1;
					rsp_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign rsp_valid = rsp_valid_q;

endmodule

@@ rtl/spq_dp.sv @@
module spq_dp
	import spq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctrl_cmd_t             cmd,
	input  logic                  req_command,
	input  logic [FIELD_ID_W-1:0] req_customer_id,
	input  logic                  req_is_priority,
	input  logic                  cfg_we,
	input  logic [SLOT_W-1:0]     cfg_wdata,
	output rsp_t                  rsp
);

	logic [ID_WIDTH-1:0] p_mem [QUEUE_DEPTH];
	logic [ID_WIDTH-1:0] g_mem [QUEUE_DEPTH];
	logic [ID_WIDTH-1:0] p_rd_q, g_rd_q;

	logic                command_q;
	logic [ID_WIDTH-1:0] id_q;
	logic                prio_q;

	logic [PTR_W-1:0]  p_head_q, p_tail_q, g_head_q, g_tail_q;
	logic [CNT_W-1:0]  p_fill_q, g_fill_q;
	logic [SLOT_W-1:0] slot_q, block_size_q;
	logic [BLK_W-1:0]  block_q;

	logic p_full, g_full, p_empty, g_empty;
	logic p_push, g_push, p_pop, g_pop, serve_ok, end_block;
	rsp_t rsp_d, rsp_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			command_q <= req_command;
			id_q      <= ID_WIDTH'(req_customer_id);
			prio_q    <= req_is_priority;
		end
	end

	assign p_full  = (p_fill_q == CNT_W'(QUEUE_DEPTH));
	assign g_full  = (g_fill_q == CNT_W'(QUEUE_DEPTH));
	assign p_empty = (p_fill_q == '0);
	assign g_empty = (g_fill_q == '0);

	assign p_push    = cmd.commit && (command_q == CMD_ENQUEUE) && prio_q && !p_full;
	assign g_push    = cmd.commit && (command_q == CMD_ENQUEUE) && !prio_q && !g_full;
	assign serve_ok  = (command_q == CMD_SERVE) && !(p_empty && g_empty);
	assign p_pop     = cmd.commit && serve_ok && !p_empty;
	assign g_pop     = cmd.commit && serve_ok && p_empty;
	assign end_block = ({1'b0, slot_q} + 7'd1) >= {1'b0, block_size_q};

	// queue storage, head entries read every cycle
	always_ff @(posedge clk) begin
		if (p_push)
			p_mem[p_tail_q] <= id_q;
		if (g_push)
			g_mem[g_tail_q] <= id_q;
		p_rd_q <= p_mem[p_head_q];
		g_rd_q <= g_mem[g_head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_head_q     <= '0;
			p_tail_q     <= '0;
			p_fill_q     <= '0;
			g_head_q     <= '0;
			g_tail_q     <= '0;
			g_fill_q     <= '0;
			slot_q       <= '0;
			block_q      <= BLOCK_NUM_RST;
			block_size_q <= BLOCK_SIZE_RST;
		end else begin
			if (cfg_we)
				block_size_q <= cfg_wdata;
			if (p_push) begin
				p_tail_q <= ptr_next(p_tail_q);
				p_fill_q <= p_fill_q + CNT_W'(1);
			end
			if (g_push) begin
				g_tail_q <= ptr_next(g_tail_q);
				g_fill_q <= g_fill_q + CNT_W'(1);
			end
			if (p_pop) begin
				p_head_q <= ptr_next(p_head_q);
				p_fill_q <= p_fill_q - CNT_W'(1);
			end
			if (g_pop) begin
				g_head_q <= ptr_next(g_head_q);
				g_fill_q <= g_fill_q - CNT_W'(1);
			end
			if (cmd.commit && serve_ok) begin
				if (end_block) begin
					slot_q  <= '0;
					block_q <= block_q + BLK_W'(1);
				end else begin
					slot_q <= slot_q + SLOT_W'(1);
				end
			end
		end
	end

	always_comb begin
		rsp_d                 = '0;
		rsp_d.block_number    = block_q;
		rsp_d.priority_count  = p_fill_q;
		rsp_d.general_count   = g_fill_q;
		rsp_d.status          = ST_OK;
		if (command_q == CMD_ENQUEUE) begin
			if (prio_q) begin
				if (p_full)
					rsp_d.status = ST_FULL;
				else
					rsp_d.priority_count = p_fill_q + CNT_W'(1);
			end else begin
				if (g_full)
					rsp_d.status = ST_FULL;
				else
					rsp_d.general_count = g_fill_q + CNT_W'(1);
			end
		end else if (!serve_ok) begin
			rsp_d.status = ST_EMPTY;
		end else begin
			rsp_d.slot_index    = slot_q;
			rsp_d.last_in_block = end_block;
			if (!p_empty) begin
				rsp_d.served_id       = FIELD_ID_W'(p_rd_q);
				rsp_d.served_priority = 1'b1;
				rsp_d.priority_count  = p_fill_q - CNT_W'(1);
			end else begin
				rsp_d.served_id     = FIELD_ID_W'(g_rd_q);
				rsp_d.general_count = g_fill_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit)
			rsp_q <= rsp_d;
	end

	assign rsp = rsp_q;

endmodule

@@ rtl/strict_priority_two_class_queue.sv @@
// result path: an input transfer is captured into registers, then the commit writes the response register
// one item at a time: no new input is taken from its capture until its commit, which waits on a held result
// a waiting result lets one more input transfer in, whose commit waits for the output transfer
// reset: queues empty, slot 0, block number 1, block size 6
// queue memory contents are not cleared by reset
module strict_priority_two_class_queue
	import spq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	spq_req_if.sink           req,
	spq_rsp_if.source         rsp,
	input  logic              cfg_we,
	input  logic [SLOT_W-1:0] cfg_wdata
);

	ctrl_cmd_t cmd;
	rsp_t      rsp_data;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	spq_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.req_command     (req.command),
		.req_customer_id (req.customer_id),
		.req_is_priority (req.is_priority),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.rsp             (rsp_data)
	);

	assign rsp.status          = rsp_data.status;
	assign rsp.served_id       = rsp_data.served_id;
	assign rsp.served_priority = rsp_data.served_priority;
	assign rsp.slot_index      = rsp_data.slot_index;
	assign rsp.last_in_block   = rsp_data.last_in_block;
	assign rsp.block_number    = rsp_data.block_number;
	assign rsp.priority_count  = rsp_data.priority_count;
	assign rsp.general_count   = rsp_data.general_count;

endmodule

@@ tb/strict_priority_two_class_queue_tb.sv @@
module strict_priority_two_class_queue_tb;
	import spq_pkg::*;

	localparam int WATCHDOG_LIMIT = 200;
	localparam int SEGMENTS       = 10;
	localparam int SEG_ITEMS      = 100;
	localparam int DIRECTED_ROWS  = 18;

	typedef struct {
		command_t    cmd;
		logic [15:0] id;
		logic        prio;
		bit          typed;
		rsp_t        want;
	} dir_row_t;

	localparam rsp_t EMPTY_B1 = '{ST_EMPTY, 16'h0000, 1'b0, 6'd0, 1'b0, 16'd1, 8'd0, 8'd0};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [SLOT_W-1:0] cfg_wdata;

	spq_req_if req_ch ();
	spq_rsp_if rsp_ch ();

	strict_priority_two_class_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// scheduler state mirrored by the testbench
	logic [15:0]       prio_ring [QUEUE_DEPTH];
	logic [15:0]       gen_ring  [QUEUE_DEPTH];
	logic [PTR_W-1:0]  prio_head = '0;
	logic [PTR_W-1:0]  prio_tail = '0;
	logic [CNT_W-1:0]  prio_fill = '0;
	logic [PTR_W-1:0]  gen_head  = '0;
	logic [PTR_W-1:0]  gen_tail  = '0;
	logic [CNT_W-1:0]  gen_fill  = '0;
	logic [SLOT_W-1:0] slot_ctr  = '0;
	logic [BLK_W-1:0]  block_num = BLOCK_NUM_RST;
	logic [SLOT_W-1:0] block_size = BLOCK_SIZE_RST;

	rsp_t     due_results [$];
	rsp_t     head_result;
	int       mismatches = 0;
	int       quiet_cycles = 0;
	bit       tx_gaps;
	bit       rx_gaps;
	dir_row_t directed [DIRECTED_ROWS];

	function automatic rsp_t schedule_step(input command_t cmd, input logic [15:0] id,
		input logic prio);
		rsp_t r;
		r = '0;
		r.block_number = block_num;
		if (cmd == CMD_ENQUEUE) begin
			if (prio) begin
				if (prio_fill == QUEUE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					prio_ring[prio_tail] = id;
					prio_tail++;
					prio_fill++;
				end
			end else begin
				if (gen_fill == QUEUE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					gen_ring[gen_tail] = id;
					gen_tail++;
					gen_fill++;
				end
			end
		end else if (prio_fill == 0 && gen_fill == 0) begin
			r.status = ST_EMPTY;
		end else begin
			if (prio_fill != 0) begin
				r.served_id = prio_ring[prio_head];
				r.served_priority = 1'b1;
				prio_head++;
				prio_fill--;
			end else begin
				r.served_id = gen_ring[gen_head];
				gen_head++;
				gen_fill--;
			end
			r.slot_index = slot_ctr;
			if (int'(slot_ctr) + 1 >= int'(block_size)) begin
				r.last_in_block = 1'b1;
				slot_ctr = '0;
				block_num++;
			end else begin
				slot_ctr++;
			end
		end
		r.priority_count = prio_fill;
		r.general_count = gen_fill;
		return r;
	endfunction

	task automatic send_item(input command_t cmd, input logic [15:0] id, input logic prio,
		input bit typed, input rsp_t want);
		int gap;
		rsp_t predicted;
		gap = tx_gaps ? $urandom_range(0, 9) : 0;
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= cmd;
		req_ch.customer_id <= id;
		req_ch.is_priority <= prio;
		do @(posedge clk); while (!req_ch.ready);
		predicted = schedule_step(cmd, id, prio);
		due_results.push_back(typed ? want : predicted);
	endtask

	task automatic send_random(input int enq_pct, input int prio_pct);
		command_t cmd;
		cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQUEUE : CMD_SERVE;
		send_item(cmd, 16'($urandom), $urandom_range(0, 99) < prio_pct, 1'b0, '0);
	endtask

	// hold off the sender until every outstanding result is back
	task automatic settle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_block_size(input logic [SLOT_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		block_size = v;
	endtask

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			if (mismatches < 40)
				$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// response side: random stalls before each transfer when rx_gaps is set
	initial begin
		int stall;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = rx_gaps ? $urandom_range(0, 9) : 0;
			@(negedge clk);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (due_results.size() == 0) begin
				if (mismatches < 40)
					$display("%0t: unexpected result expected none actual id %0h status %0h",
						$time, rsp_ch.served_id, rsp_ch.status);
				mismatches++;
			end else begin
				head_result = due_results.pop_front();
				check_field("status", head_result.status, rsp_ch.status);
				check_field("served_id", head_result.served_id, rsp_ch.served_id);
				check_field("served_priority", head_result.served_priority,
					rsp_ch.served_priority);
				check_field("slot_index", head_result.slot_index, rsp_ch.slot_index);
				check_field("last_in_block", head_result.last_in_block, rsp_ch.last_in_block);
				check_field("block_number", head_result.block_number, rsp_ch.block_number);
				check_field("priority_count", head_result.priority_count,
					rsp_ch.priority_count);
				check_field("general_count", head_result.general_count, rsp_ch.general_count);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int seg;
		int n;
		int enq_pct;
		int prio_pct;
		logic [SLOT_W-1:0] seg_size;

		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_ENQUEUE;
		req_ch.customer_id = '0;
		req_ch.is_priority = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;

		directed = '{
			'{CMD_SERVE,   16'h0000, 1'b0, 1'b1, EMPTY_B1},
			'{CMD_SERVE,   16'hFFFF, 1'b1, 1'b1, EMPTY_B1},
			'{CMD_ENQUEUE, 16'hFFFF, 1'b0, 1'b1,
				'{ST_OK, 16'h0000, 1'b0, 6'd0, 1'b0, 16'd1, 8'd0, 8'd1}},
			'{CMD_ENQUEUE, 16'h0000, 1'b1, 1'b1,
				'{ST_OK, 16'h0000, 1'b0, 6'd0, 1'b0, 16'd1, 8'd1, 8'd1}},
			'{CMD_ENQUEUE, 16'hA5A5, 1'b1, 1'b0, '0},
			'{CMD_ENQUEUE, 16'h5A5A, 1'b0, 1'b0, '0},
			'{CMD_SERVE,   16'h0000, 1'b0, 1'b1,
				'{ST_OK, 16'h0000, 1'b1, 6'd0, 1'b0, 16'd1, 8'd1, 8'd2}},
			'{CMD_ENQUEUE, 16'h8001, 1'b1, 1'b0, '0},
			'{CMD_SERVE,   16'h1234, 1'b0, 1'b0, '0},
			'{CMD_SERVE,   16'h0000, 1'b1, 1'b0, '0},
			'{CMD_SERVE,   16'h0000, 1'b0, 1'b0, '0},
			'{CMD_SERVE,   16'h0000, 1'b0, 1'b0, '0},
			'{CMD_SERVE,   16'hFFFF, 1'b1, 1'b1, EMPTY_B1},
			'{CMD_ENQUEUE, 16'h0001, 1'b0, 1'b0, '0},
			'{CMD_ENQUEUE, 16'h7FFF, 1'b1, 1'b0, '0},
			'{CMD_SERVE,   16'h0000, 1'b0, 1'b0, '0},
			'{CMD_SERVE,   16'h0000, 1'b0, 1'b0, '0},
			'{CMD_SERVE,   16'h0000, 1'b0, 1'b0, '0}
		};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed[i])
			send_item(directed[i].cmd, directed[i].id, directed[i].prio, directed[i].typed,
				directed[i].want);

		// overfill both queues, then drain them past empty
		settle();
		for (n = 0; n <= QUEUE_DEPTH; n++)
			send_item(CMD_ENQUEUE, 16'($urandom), 1'b1, 1'b0, '0);
		for (n = 0; n <= QUEUE_DEPTH; n++)
			send_item(CMD_ENQUEUE, 16'($urandom), 1'b0, 1'b0, '0);
		for (n = 0; n <= 2 * QUEUE_DEPTH; n++)
			send_item(CMD_SERVE, 16'($urandom), 1'($urandom), 1'b0, '0);

		for (seg = 0; seg < SEGMENTS; seg++) begin
			settle();
			if (seg == 5) begin
				// one-slot blocks at full rate
				tx_gaps = 1'b0;
				rx_gaps = 1'b0;
				set_block_size(6'd1);
				for (n = 0; n < 16; n++) begin
					send_item(CMD_ENQUEUE, 16'($urandom), 1'($urandom), 1'b0, '0);
					send_item(CMD_SERVE, 16'($urandom), 1'($urandom), 1'b0, '0);
				end
				settle();
			end
			case (seg)
				0: seg_size = 6'd63;
				1: seg_size = 6'd2;
				2: seg_size = 6'd0;
				3: seg_size = 6'd1;
				9: seg_size = BLOCK_SIZE_RST;
				default: seg_size = 6'($urandom_range(0, 63));
			endcase
			set_block_size(seg_size);
			case (seg)
				0: begin
					tx_gaps = 1'b1;
					rx_gaps = 1'b1;
				end
				1: begin
					tx_gaps = 1'b0;
					rx_gaps = 1'b0;
				end
				default: begin
					tx_gaps = ($urandom_range(0, 2) != 0);
					rx_gaps = ($urandom_range(0, 2) != 0);
				end
			endcase
			case ($urandom_range(0, 2))
				0: enq_pct = 20;
				1: enq_pct = 50;
				default: enq_pct = 80;
			endcase
			prio_pct = $urandom_range(0, 100);
			for (n = 0; n < SEG_ITEMS; n++)
				send_random(enq_pct, prio_pct);
		end

		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
